### rtl/core/fp32_rsqrt_newton_macros.svh
// assertion macros shared by the reciprocal square root pipeline
// no dependencies; included by files that carry concurrent checks
`ifndef FP32_RSQRT_NEWTON_MACROS_SVH
`define FP32_RSQRT_NEWTON_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("implication check failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("next-cycle check failed");

`endif

### rtl/core/fprsqrt_pkg.sv
// types, constants and the estimate table for the fp32 reciprocal square root
// no dependencies
package fprsqrt_pkg;

   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam logic [31:0] NEG_INF   = 32'hFF80_0000;
   localparam int unsigned STAGES    = 7;

   typedef struct packed {
      logic [31:0] x_bits;
      logic        in_last;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] y_bits;
      logic        out_last;
   } rsp_payload_type;

   // estimate stage result: y0 = my * 2^(oexp-134), y2 = my2 * 2^(2*oexp-268)
   typedef struct packed {
      logic               special;
      logic               last;
      logic               y2_inf;
      logic [7:0]         my;
      logic [7:0]         oexp;
      logic [15:0]        my2;
      logic [23:0]        mx;
      logic signed [10:0] ee;
   } est_type;

   localparam logic [6:0] RSQ_TABLE [128] = '{
      7'd52, 7'd51, 7'd50, 7'd48, 7'd47, 7'd46, 7'd44, 7'd43,
      7'd42, 7'd41, 7'd40, 7'd39, 7'd38, 7'd36, 7'd35, 7'd34,
      7'd33, 7'd32, 7'd31, 7'd30, 7'd30, 7'd29, 7'd28, 7'd27,
      7'd26, 7'd25, 7'd24, 7'd23, 7'd23, 7'd22, 7'd21, 7'd20,
      7'd19, 7'd19, 7'd18, 7'd17, 7'd16, 7'd16, 7'd15, 7'd14,
      7'd14, 7'd13, 7'd12, 7'd12, 7'd11, 7'd10, 7'd10, 7'd9,
      7'd9, 7'd8, 7'd7, 7'd7, 7'd6, 7'd6, 7'd5, 7'd4,
      7'd4, 7'd3, 7'd3, 7'd2, 7'd2, 7'd1, 7'd1, 7'd0,
      7'd127, 7'd125, 7'd123, 7'd121, 7'd119, 7'd118, 7'd116, 7'd114,
      7'd113, 7'd111, 7'd109, 7'd108, 7'd106, 7'd105, 7'd103, 7'd102,
      7'd100, 7'd99, 7'd97, 7'd96, 7'd95, 7'd93, 7'd92, 7'd91,
      7'd90, 7'd88, 7'd87, 7'd86, 7'd85, 7'd84, 7'd83, 7'd82,
      7'd80, 7'd79, 7'd78, 7'd77, 7'd76, 7'd75, 7'd74, 7'd73,
      7'd72, 7'd71, 7'd70, 7'd70, 7'd69, 7'd68, 7'd67, 7'd66,
      7'd65, 7'd64, 7'd63, 7'd63, 7'd62, 7'd61, 7'd60, 7'd59,
      7'd59, 7'd58, 7'd57, 7'd56, 7'd56, 7'd55, 7'd54, 7'd53
   };

endpackage

### rtl/core/fprsqrt_est.sv
// estimate stages: classify and normalize x, table lookup, exact square of y0
// depends on fprsqrt_pkg
module fprsqrt_est import fprsqrt_pkg::*; (
   input  logic            clock,
   input  logic [1:0]      en,
   input  req_payload_type req_data,
   output est_type         est
);

   logic               s1_special_ff, s1_special_in;
   logic               s1_last_ff;
   logic [23:0]        s1_mx_ff, s1_mx_in;
   logic signed [10:0] s1_e_ff, s1_e_in;
   logic [6:0]         s1_idx_ff, s1_idx_in;
   est_type            s2_ff, s2_in;

   logic [7:0]         ex;
   logic [22:0]        fr;
   logic [4:0]         lz;
   logic [23:0]        fr_sh;
   logic [22:0]        fr_n;
   logic signed [10:0] two_oexp;
   logic signed [10:0] oexp_t;
   logic [7:0]         oexp_c;
   logic [7:0]         my_c;

   // stage 1: classify, normalize subnormals
   always_comb begin
      ex = req_data.x_bits[30:23];
      fr = req_data.x_bits[22:0];
      lz = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (fr[i]) begin
            lz = 5'(22 - i);
         end
      end
      fr_sh = {fr, 1'b0} << lz;
      fr_n  = fr_sh[22:0];
      s1_special_in = (ex == 8'hFF) || (ex == 8'h00 && fr == 23'd0) || req_data.x_bits[31];
      if (ex == 8'h00) begin
         s1_mx_in  = {1'b1, fr_n};
         s1_e_in   = -$signed({6'b0, lz});
         s1_idx_in = {s1_e_in[0], fr_n[22:17]};
      end else begin
         s1_mx_in  = {1'b1, fr};
         s1_e_in   = $signed({3'b0, ex});
         s1_idx_in = {ex[0], fr[22:17]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_special_ff <= s1_special_in;
         s1_last_ff    <= req_data.in_last;
         s1_mx_ff      <= s1_mx_in;
         s1_e_ff       <= s1_e_in;
         s1_idx_ff     <= s1_idx_in;
      end
   end

   // stage 2: table, result exponent, y0 squared (exact, 16 bits)
   always_comb begin
      oexp_t   = 11'sd380 - s1_e_ff;
      oexp_c   = oexp_t[8:1];
      two_oexp = {2'b00, oexp_c, 1'b0};
      my_c     = {1'b1, RSQ_TABLE[s1_idx_ff]};
      s2_in.special = s1_special_ff;
      s2_in.last    = s1_last_ff;
      // y0*y0 reaches 2^128 exactly when the exponent is this large
      s2_in.y2_inf  = (oexp_c >= 8'd191);
      s2_in.my      = my_c;
      s2_in.oexp    = oexp_c;
      s2_in.my2     = 16'({8'd0, my_c} * {8'd0, my_c});
      s2_in.mx      = s1_mx_ff;
      s2_in.ee      = s1_e_ff + two_oexp - 11'sd418;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_ff <= s2_in;
      end
   end

   assign est = s2_ff;

endmodule

### rtl/core/fprsqrt_refine.sv
// newton step stages: x*y2, round, 1.5 - half, y0*corr, round and pack
// depends on fprsqrt_pkg
module fprsqrt_refine import fprsqrt_pkg::*; (
   input  logic            clock,
   input  logic [4:0]      en,
   input  est_type         est,
   output rsp_payload_type rsp_data
);

   // stage 3
   logic               s3_special_ff, s3_last_ff, s3_inf_ff;
   logic [7:0]         s3_my_ff, s3_oexp_ff;
   logic [39:0]        s3_p_ff, s3_p_in;
   logic signed [10:0] s3_ee_ff;
   // stage 4
   logic               s4_special_ff, s4_last_ff, s4_inf_ff;
   logic [7:0]         s4_my_ff, s4_oexp_ff;
   logic [23:0]        s4_m_ff, s4_m_in;
   logic [1:0]         s4_s_ff, s4_s_in;
   // stage 5
   logic               s5_special_ff, s5_last_ff, s5_inf_ff;
   logic [7:0]         s5_my_ff, s5_oexp_ff;
   logic [23:0]        s5_mc_ff, s5_mc_in;
   logic [1:0]         s5_cexp_ff, s5_cexp_in;
   // stage 6
   logic               s6_special_ff, s6_last_ff, s6_inf_ff;
   logic [7:0]         s6_oexp_ff;
   logic [31:0]        s6_r_ff, s6_r_in;
   logic [1:0]         s6_cexp_ff;
   // stage 7
   rsp_payload_type    s7_ff, s7_in;

   logic [4:0]         sh4;
   logic [39:0]        p_shr, p_low;
   logic               g4, st4;
   logic [24:0]        rnd4;
   logic signed [10:0] s_full;
   logic [25:0]        d5;
   logic [23:0]        b5;
   logic               g5, st5;
   logic [24:0]        rnd5;
   logic [3:0]         sh7;
   logic [31:0]        r_shr, r_low;
   logic               g7, st7;
   logic [24:0]        rnd7;
   logic [8:0]         bexp7;

   // stage 3: x * y2, exact 40-bit product
   assign s3_p_in = {16'd0, est.mx} * {24'd0, est.my2};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s3_special_ff <= est.special;
         s3_last_ff    <= est.last;
         s3_inf_ff     <= est.y2_inf;
         s3_my_ff      <= est.my;
         s3_oexp_ff    <= est.oexp;
         s3_p_ff       <= s3_p_in;
         s3_ee_ff      <= est.ee;
      end
   end

   // stage 4: round x*y2 to 24 bits; the product sits near one
   always_comb begin
      if (s3_p_ff[39]) begin
         sh4 = 5'd16;
      end else if (s3_p_ff[38]) begin
         sh4 = 5'd15;
      end else begin
         sh4 = 5'd14;
      end
      p_shr = s3_p_ff >> sh4;
      p_low = s3_p_ff & ((40'd1 << (sh4 - 5'd1)) - 40'd1);
      g4    = s3_p_ff[sh4 - 5'd1];
      st4   = |p_low;
      rnd4  = {1'b0, p_shr[23:0]} + {24'd0, g4 & (st4 | p_shr[0])};
      s4_m_in = rnd4[24] ? 24'h80_0000 : rnd4[23:0];
      // alignment of half = xy2/2 against 1.5 in units of 2^-25
      s_full  = s3_ee_ff + $signed({6'd0, sh4}) + $signed({10'd0, rnd4[24]}) + 11'sd24;
      s4_s_in = s_full[1:0];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s4_special_ff <= s3_special_ff;
         s4_last_ff    <= s3_last_ff;
         s4_inf_ff     <= s3_inf_ff;
         s4_my_ff      <= s3_my_ff;
         s4_oexp_ff    <= s3_oexp_ff;
         s4_m_ff       <= s4_m_in;
         s4_s_ff       <= s4_s_in;
      end
   end

   // stage 5: corr = 1.5 - half, exact difference then round
   always_comb begin
      d5 = 26'h300_0000 - ({2'b00, s4_m_ff} << s4_s_ff);
      if (d5[25]) begin
         b5  = d5[25:2];
         g5  = d5[1];
         st5 = d5[0];
         s5_cexp_in = 2'd1;
      end else begin
         b5  = d5[24:1];
         g5  = d5[0];
         st5 = 1'b0;
         s5_cexp_in = 2'd0;
      end
      rnd5 = {1'b0, b5} + {24'd0, g5 & (st5 | b5[0])};
      if (rnd5[24]) begin
         s5_mc_in   = 24'h80_0000;
         s5_cexp_in = s5_cexp_in + 2'd1;
      end else begin
         s5_mc_in = rnd5[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s5_special_ff <= s4_special_ff;
         s5_last_ff    <= s4_last_ff;
         s5_inf_ff     <= s4_inf_ff;
         s5_my_ff      <= s4_my_ff;
         s5_oexp_ff    <= s4_oexp_ff;
         s5_mc_ff      <= s5_mc_in;
         s5_cexp_ff    <= s5_cexp_in;
      end
   end

   // stage 6: y0 * corr
   assign s6_r_in = {24'd0, s5_my_ff} * {8'd0, s5_mc_ff};

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s6_special_ff <= s5_special_ff;
         s6_last_ff    <= s5_last_ff;
         s6_inf_ff     <= s5_inf_ff;
         s6_oexp_ff    <= s5_oexp_ff;
         s6_r_ff       <= s6_r_in;
         s6_cexp_ff    <= s5_cexp_ff;
      end
   end

   // stage 7: round, pack, special classes
   always_comb begin
      sh7   = s6_r_ff[31] ? 4'd8 : 4'd7;
      r_shr = s6_r_ff >> sh7;
      r_low = s6_r_ff & ((32'd1 << (sh7 - 4'd1)) - 32'd1);
      g7    = s6_r_ff[sh7 - 4'd1];
      st7   = |r_low;
      rnd7  = {1'b0, r_shr[23:0]} + {24'd0, g7 & (st7 | r_shr[0])};
      bexp7 = {1'b0, s6_oexp_ff} - 9'd8 + {7'd0, s6_cexp_ff} + {5'd0, sh7}
            + {8'd0, rnd7[24]};
      s7_in.out_last = s6_last_ff;
      if (s6_special_ff) begin
         s7_in.y_bits = CANON_NAN;
      end else if (s6_inf_ff) begin
         // y2 overflowed, so corr is -inf
         s7_in.y_bits = NEG_INF;
      end else if (rnd7[24]) begin
         s7_in.y_bits = {1'b0, bexp7[7:0], 23'd0};
      end else begin
         s7_in.y_bits = {1'b0, bexp7[7:0], rnd7[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s7_ff <= s7_in;
      end
   end

   assign rsp_data = s7_ff;

endmodule

### rtl/core/fp32_rsqrt_newton.sv
// fp32 reciprocal square root, 7-bit table estimate plus one Newton-Raphson
// step, the x*y2 and y0*corr products and the subtract rounded to nearest
// even. Seven register stages: an item enters every cycle and throughput is
// one item per cycle while the output does not stall, set by the stage chain
// with a valid bit per stage. A stalled output holds only the stages that are
// full, so bubbles upstream still fill. NaN, negative, zero and infinite inputs
// give the canonical NaN 0x7FC00000. The last marker rides along unchanged.
`include "fp32_rsqrt_newton_macros.svh"

module fp32_rsqrt_newton import fprsqrt_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] en;
   est_type           est;

   // a stage loads when it is empty or its successor moves
   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   fprsqrt_est u_est (
      .clock    (clock),
      .en       (en[1:0]),
      .req_data (req_data),
      .est      (est)
   );

   fprsqrt_refine u_refine (
      .clock    (clock),
      .en       (en[STAGES-1:2]),
      .est      (est),
      .rsp_data (rsp_data)
   );

   `ASSERT_IMPLY(a_stall_only_full, clock, reset, req_stall, valid_ff[0])
   `ASSERT_NEXT(a_drain_empties, clock, reset,
                rsp_valid && !rsp_stall && !valid_ff[STAGES-2], !rsp_valid)
   `ASSERT_NEXT(a_item_arrives, clock, reset,
                valid_ff[STAGES-2] && en[STAGES-1], rsp_valid)

endmodule
